[sv/tpcm_pkg.sv]
// Package for the three-point circle momentum block: field widths, derived
// arithmetic widths, status codes and the beat payload structs.
// No dependencies; every RTL file of the block imports it.
package tpcm_pkg;

  localparam int COORD_BITS = 32;
  localparam int FIELD_BITS = 16;
  localparam int RAD_BITS   = 32;
  localparam int MOM_BITS   = 32;

  // Chord components and their magnitudes, also the limb width of the
  // partial products.
  localparam int DW  = COORD_BITS + 1;
  localparam int LW  = DW;
  localparam int NW  = 2 * LW;              // squared length, |cross|
  localparam int XW  = 2 * DW + 1;          // signed cross product
  localparam int PW  = 4 * LW;              // |a|^2*|b|^2, cross^2
  localparam int UW  = 5 * LW;              // partial sums of the numerator
  localparam int NNW = 6 * LW;              // |a|^2*|b|^2*|c|^2
  localparam int DVW = PW + 2;              // 4*cross^2
  localparam int QW  = 2 * RAD_BITS;        // quotient before the square root
  localparam int HIW = NNW - QW;
  localparam int RMW = ((HIW > DVW) ? HIW : DVW) + 1;
  localparam int SPW = DW + LW + 1;         // signed partial of the side term
  localparam int SW  = DW + NW + 3;         // signed side term
  localparam int SRW = RAD_BITS + 3;        // square-root remainder

  localparam int P_SCALE     = 300;
  localparam int FPW         = FIELD_BITS + 9;
  localparam int PRW         = FPW + RAD_BITS;
  localparam int ROUND_SHIFT = 12;
  localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
  localparam int MGW         = PRW - ROUND_SHIFT;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_VERT = 2'd1,
    ST_COLL = 2'd2,
    ST_FLAT = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z_first;
    logic signed [COORD_BITS-1:0] y_first;
    logic signed [COORD_BITS-1:0] z_middle;
    logic signed [COORD_BITS-1:0] y_middle;
    logic signed [COORD_BITS-1:0] z_last;
    logic signed [COORD_BITS-1:0] y_last;
    logic signed [FIELD_BITS-1:0] field_x;
  } in_data_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]        radius;
    logic signed [MOM_BITS-1:0] momentum;
    status_t                    status;
  } out_data_t;

  // What travels alongside the wide arithmetic once the charge is known.
  typedef struct packed {
    status_t        status;
    logic           neg;
    logic [FPW-1:0] f300;
  } tail_t;

endpackage

[sv/three_point_circle_momentum_top.sv]
// Three-point circle momentum: the circle through three hits, its radius
// and the signed transverse momentum in the given field, fully pipelined.
// Depends on tpcm_pkg.
//
// Usage
//   Input beats carry three (z,y) hits and the field at the middle hit on
//   in_valid/in_ready/in_data; result beats carry radius, momentum and status
//   on out_valid/out_ready/out_data. One result leaves for every input.
//   A new triplet can be taken every cycle while the pipeline is not frozen
//   (see below); the pipeline runs through the restoring divider (one
//   quotient bit per stage, 64 stages) and the digit-by-digit square root
//   (one root bit per stage, 32 stages) that follow eight stages of chord,
//   cross-product and partial-product arithmetic.
//   rst_n (synchronous, active low) empties the pipeline and the output
//   register; no item is in flight afterwards.
//   When the receiver stalls, a finished result waits in the output
//   register. The pipeline keeps moving and accepting input as long as its
//   last stage is empty; it freezes as a whole only when that stage holds a
//   result as well.
//   Vertical chords, collinear hits and a level last chord give status
//   codes 1 to 3 and zero radius and momentum.
module three_point_circle_momentum_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tpcm_pkg::in_data_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tpcm_pkg::out_data_t  out_data
);
  import tpcm_pkg::*;

  localparam int TOT      = 8 + (QW + 1) + (RAD_BITS + 1) + 1;
  localparam int DIV_BASE = 8;
  localparam int DIV_LAST = DIV_BASE + QW;
  localparam int SQ_BASE  = DIV_LAST + 1;
  localparam int SQ_LAST  = SQ_BASE + RAD_BITS;
  localparam int RW       = RAD_BITS;
  localparam logic [MOM_BITS-1:0] MOM_POS_MAX = {1'b0, {(MOM_BITS-1){1'b1}}};
  localparam logic [MOM_BITS-1:0] MOM_NEG_MAX = {1'b1, {(MOM_BITS-1){1'b0}}};

  logic           adv;
  logic           in_fire;
  logic [TOT-1:0] v_r;
  logic           out_valid_r;
  out_data_t      out_data_r;

  // Stage 1: chords.
  logic signed [DW-1:0]  dl_r [0:5];
  logic signed [DW-1:0]  dl_nxt [0:5];
  logic [FIELD_BITS-1:0] fmag;
  logic [FPW-1:0]        f300_1_r, f300_1_nxt;
  logic                  fneg1_r;
  // Stage 2: products.
  logic signed [2*DW-1:0] pab_r, pba_r, pab_nxt, pba_nxt;
  logic [NW-1:0]          sq_r [0:5];
  logic [NW-1:0]          sq_nxt [0:5];
  logic                   vert2_r, byz2_r, fneg2_r;
  logic signed [DW-1:0]   az2_r, bz2_r;
  logic [FPW-1:0]         f300_2_r;
  // Stage 3: cross product and squared lengths.
  logic signed [XW-1:0] cross3_r, cross3_nxt;
  logic [NW-1:0]        na3_r, nb3_r, nc3_r;
  logic                 vert3_r, byz3_r, fneg3_r;
  logic signed [DW-1:0] az3_r, bz3_r;
  logic [FPW-1:0]       f300_3_r;
  // Stage 4: status, |cross| and first partial products.
  logic [XW-1:0]         cabs;
  logic [NW-1:0]         crm4_r;
  status_t               st4_r, st4_nxt;
  logic                  cpos4_r, cneg4_r, fneg4_r;
  logic [NW-1:0]         pp4_r [0:1][0:1];
  logic [NW-1:0]         pp4_nxt [0:1][0:1];
  logic signed [SPW-1:0] spa4_r [0:1];
  logic signed [SPW-1:0] spb4_r [0:1];
  logic signed [SPW-1:0] spa4_nxt [0:1];
  logic signed [SPW-1:0] spb4_nxt [0:1];
  logic [NW-1:0]         nc4_r;
  logic [FPW-1:0]        f300_4_r;
  // Stage 5.
  logic [PW-1:0]        nab5_r, nab5_nxt;
  logic signed [SW-1:0] s5_r, s5_nxt;
  logic [NW-1:0]        cp5_r [0:1][0:1];
  logic [NW-1:0]        cp5_nxt [0:1][0:1];
  logic [NW-1:0]        nc5_r;
  status_t              st5_r;
  logic                 cpos5_r, cneg5_r, fneg5_r;
  logic [FPW-1:0]       f300_5_r;
  // Stage 6.
  logic [NW-1:0] qp6_r [0:3][0:1];
  logic [NW-1:0] qp6_nxt [0:3][0:1];
  logic [PW-1:0] d4_6_r, d4_6_nxt;
  logic          above;
  tail_t         tl6_r, tl6_nxt;
  // Stage 7 and 8.
  logic [UW-1:0]  u7_r [0:1];
  logic [UW-1:0]  u7_nxt [0:1];
  logic [DVW-1:0] d7_r;
  tail_t          tl7_r;
  logic [NNW-1:0] n8_r, n8_nxt;
  logic [DVW-1:0] d8_r;
  tail_t          tl8_r;
  // Divider, one quotient bit per stage.
  logic [RMW-1:0] drem_r [0:QW];
  logic [QW-1:0]  dlo_r [0:QW];
  logic [QW-1:0]  dq_r [0:QW];
  logic [DVW-1:0] dd_r [0:QW];
  logic           dovf_r [0:QW];
  tail_t          dtl_r [0:QW];
  logic [RMW-1:0] dtry [1:QW];
  logic [RMW-1:0] drem_nxt [1:QW];
  logic [QW-1:0]  dq_nxt [1:QW];
  // Square root, one root bit per stage.
  logic [SRW-1:0] srem_r [0:RW];
  logic [RW-1:0]  sroot_r [0:RW];
  logic [QW-1:0]  ssrc_r [0:RW];
  logic           sovf_r [0:RW];
  tail_t          stl_r [0:RW];
  logic [SRW-1:0] stry [1:RW];
  logic [SRW-1:0] strial [1:RW];
  logic [SRW-1:0] srem_nxt [1:RW];
  logic [RW-1:0]  sroot_nxt [1:RW];
  // Momentum product.
  logic [RW-1:0]  rad;
  logic [RW-1:0]  mrad_r;
  logic [PRW-1:0] mprod_r, mprod_nxt;
  tail_t          mtl_r;
  logic [MGW-1:0] mag;
  out_data_t      res;

  // The pipeline moves unless its last stage and the output register are
  // both full and the receiver is stalling.
  assign adv       = !v_r[TOT-1] || !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v_r <= {v_r[TOT-2:0], in_fire};
      end
      if (adv && v_r[TOT-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    dl_nxt[0] = $signed({in_data.z_middle[COORD_BITS-1], in_data.z_middle})
              - $signed({in_data.z_first[COORD_BITS-1], in_data.z_first});
    dl_nxt[1] = $signed({in_data.y_middle[COORD_BITS-1], in_data.y_middle})
              - $signed({in_data.y_first[COORD_BITS-1], in_data.y_first});
    dl_nxt[2] = $signed({in_data.z_last[COORD_BITS-1], in_data.z_last})
              - $signed({in_data.z_middle[COORD_BITS-1], in_data.z_middle});
    dl_nxt[3] = $signed({in_data.y_last[COORD_BITS-1], in_data.y_last})
              - $signed({in_data.y_middle[COORD_BITS-1], in_data.y_middle});
    dl_nxt[4] = $signed({in_data.z_last[COORD_BITS-1], in_data.z_last})
              - $signed({in_data.z_first[COORD_BITS-1], in_data.z_first});
    dl_nxt[5] = $signed({in_data.y_last[COORD_BITS-1], in_data.y_last})
              - $signed({in_data.y_first[COORD_BITS-1], in_data.y_first});
    fmag = in_data.field_x[FIELD_BITS-1] ? FIELD_BITS'(-in_data.field_x)
                                         : in_data.field_x;
    f300_1_nxt = FPW'(fmag) * FPW'(P_SCALE);

    pab_nxt = dl_r[0] * dl_r[3];
    pba_nxt = dl_r[1] * dl_r[2];
    for (int k = 0; k < 6; k++) begin
      sq_nxt[k] = dl_r[k] * dl_r[k];
    end

    cross3_nxt = $signed({pab_r[2*DW-1], pab_r}) - $signed({pba_r[2*DW-1], pba_r});

    cabs = cross3_r[XW-1] ? -cross3_r : cross3_r;
    if (vert3_r) begin
      st4_nxt = ST_VERT;
    end else if (cross3_r == '0) begin
      st4_nxt = ST_COLL;
    end else if (byz3_r) begin
      st4_nxt = ST_FLAT;
    end else begin
      st4_nxt = ST_OK;
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        pp4_nxt[i][j] = na3_r[i*LW +: LW] * nb3_r[j*LW +: LW];
        cp5_nxt[i][j] = crm4_r[i*LW +: LW] * crm4_r[j*LW +: LW];
      end
      spa4_nxt[i] = az3_r * $signed({1'b0, nb3_r[i*LW +: LW]});
      spb4_nxt[i] = bz3_r * $signed({1'b0, na3_r[i*LW +: LW]});
    end

    nab5_nxt = {pp4_r[1][1], pp4_r[0][0]} + (PW'(pp4_r[0][1]) << LW)
             + (PW'(pp4_r[1][0]) << LW);
    // Side term az*|b|^2 + bz*|a|^2: its sign against the cross product's
    // tells whether the middle hit lies above the centre.
    s5_nxt = (SW'(spa4_r[1]) <<< LW) + SW'(spa4_r[0])
           + (SW'(spb4_r[1]) <<< LW) + SW'(spb4_r[0]);

    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        qp6_nxt[i][j] = nab5_r[i*LW +: LW] * nc5_r[j*LW +: LW];
      end
    end
    d4_6_nxt = {cp5_r[1][1], cp5_r[0][0]} + (PW'(cp5_r[0][1]) << LW)
             + (PW'(cp5_r[1][0]) << LW);
    above = (!s5_r[SW-1] && (s5_r != '0) && cneg5_r) || (s5_r[SW-1] && cpos5_r);
    tl6_nxt.status = st5_r;
    tl6_nxt.neg    = !above ^ fneg5_r;
    tl6_nxt.f300   = f300_5_r;

    // Even and odd limb products of one column do not overlap, so each
    // column is two concatenations and one add.
    for (int j = 0; j < 2; j++) begin
      u7_nxt[j] = UW'({qp6_r[2][j], qp6_r[0][j]})
                + (UW'({qp6_r[3][j], qp6_r[1][j]}) << LW);
    end
    n8_nxt = NNW'(u7_r[0]) + (NNW'(u7_r[1]) << LW);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        dl_r[k] <= dl_nxt[k];
        sq_r[k] <= sq_nxt[k];
      end
      f300_1_r <= f300_1_nxt;
      fneg1_r  <= in_data.field_x[FIELD_BITS-1];

      pab_r    <= pab_nxt;
      pba_r    <= pba_nxt;
      vert2_r  <= (dl_r[0] == '0) || (dl_r[2] == '0);
      byz2_r   <= (dl_r[3] == '0);
      az2_r    <= dl_r[0];
      bz2_r    <= dl_r[2];
      fneg2_r  <= fneg1_r;
      f300_2_r <= f300_1_r;

      cross3_r <= cross3_nxt;
      na3_r    <= sq_r[0] + sq_r[1];
      nb3_r    <= sq_r[2] + sq_r[3];
      nc3_r    <= sq_r[4] + sq_r[5];
      vert3_r  <= vert2_r;
      byz3_r   <= byz2_r;
      az3_r    <= az2_r;
      bz3_r    <= bz2_r;
      fneg3_r  <= fneg2_r;
      f300_3_r <= f300_2_r;

      crm4_r   <= cabs[NW-1:0];
      st4_r    <= st4_nxt;
      cpos4_r  <= !cross3_r[XW-1] && (cross3_r != '0);
      cneg4_r  <= cross3_r[XW-1];
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp4_r[i][j] <= pp4_nxt[i][j];
          cp5_r[i][j] <= cp5_nxt[i][j];
        end
        spa4_r[i] <= spa4_nxt[i];
        spb4_r[i] <= spb4_nxt[i];
      end
      nc4_r    <= nc3_r;
      fneg4_r  <= fneg3_r;
      f300_4_r <= f300_3_r;

      nab5_r   <= nab5_nxt;
      s5_r     <= s5_nxt;
      nc5_r    <= nc4_r;
      st5_r    <= st4_r;
      cpos5_r  <= cpos4_r;
      cneg5_r  <= cneg4_r;
      fneg5_r  <= fneg4_r;
      f300_5_r <= f300_4_r;

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          qp6_r[i][j] <= qp6_nxt[i][j];
        end
      end
      d4_6_r <= d4_6_nxt;
      tl6_r  <= tl6_nxt;

      u7_r[0] <= u7_nxt[0];
      u7_r[1] <= u7_nxt[1];
      d7_r    <= {d4_6_r, 2'b00};
      tl7_r   <= tl6_r;

      n8_r  <= n8_nxt;
      d8_r  <= d7_r;
      tl8_r <= tl7_r;
    end
  end

  // Restoring division of the numerator by 4*cross^2. A quotient that
  // would not fit the 64 bits saturates the radius instead.
  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      dtry[k] = {drem_r[k-1][RMW-2:0], dlo_r[k-1][QW-1]};
      if (dtry[k] >= RMW'(dd_r[k-1])) begin
        drem_nxt[k] = dtry[k] - RMW'(dd_r[k-1]);
        dq_nxt[k]   = {dq_r[k-1][QW-2:0], 1'b1};
      end else begin
        drem_nxt[k] = dtry[k];
        dq_nxt[k]   = {dq_r[k-1][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drem_r[0] <= RMW'(n8_r[NNW-1:QW]);
      dlo_r[0]  <= n8_r[QW-1:0];
      dq_r[0]   <= '0;
      dd_r[0]   <= d8_r;
      dovf_r[0] <= RMW'(n8_r[NNW-1:QW]) >= RMW'(d8_r);
      dtl_r[0]  <= tl8_r;
      for (int k = 1; k <= QW; k++) begin
        drem_r[k] <= drem_nxt[k];
        dlo_r[k]  <= {dlo_r[k-1][QW-2:0], 1'b0};
        dq_r[k]   <= dq_nxt[k];
        dd_r[k]   <= dd_r[k-1];
        dovf_r[k] <= dovf_r[k-1];
        dtl_r[k]  <= dtl_r[k-1];
      end
    end
  end

  // Digit-by-digit integer square root of the quotient, two input bits in
  // and one root bit out per stage.
  always_comb begin
    for (int j = 1; j <= RW; j++) begin
      stry[j]   = {srem_r[j-1][SRW-3:0], ssrc_r[j-1][QW-1:QW-2]};
      strial[j] = SRW'({sroot_r[j-1], 2'b01});
      if (stry[j] >= strial[j]) begin
        srem_nxt[j]  = stry[j] - strial[j];
        sroot_nxt[j] = {sroot_r[j-1][RW-2:0], 1'b1};
      end else begin
        srem_nxt[j]  = stry[j];
        sroot_nxt[j] = {sroot_r[j-1][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      ssrc_r[0]  <= dq_r[QW];
      sovf_r[0]  <= dovf_r[QW];
      stl_r[0]   <= dtl_r[QW];
      for (int j = 1; j <= RW; j++) begin
        srem_r[j]  <= srem_nxt[j];
        sroot_r[j] <= sroot_nxt[j];
        ssrc_r[j]  <= {ssrc_r[j-1][QW-3:0], 2'b00};
        sovf_r[j]  <= sovf_r[j-1];
        stl_r[j]   <= stl_r[j-1];
      end
    end
  end

  always_comb begin
    rad       = sovf_r[RW] ? '1 : sroot_r[RW];
    mprod_nxt = PRW'(stl_r[RW].f300) * PRW'(rad);

    mag = MGW'((mprod_r + PRW'(ROUND_HALF)) >> ROUND_SHIFT);
    res.status = mtl_r.status;
    if (mtl_r.status != ST_OK) begin
      res.radius   = '0;
      res.momentum = '0;
    end else begin
      res.radius = mrad_r;
      if (!mtl_r.neg) begin
        res.momentum = (mag > MGW'(MOM_POS_MAX)) ? MOM_POS_MAX : mag[MOM_BITS-1:0];
      end else begin
        res.momentum = (mag >= MGW'(MOM_NEG_MAX)) ? MOM_NEG_MAX
                                                  : -mag[MOM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mrad_r  <= rad;
      mprod_r <= mprod_nxt;
      mtl_r   <= stl_r[RW];
    end
    if (adv && v_r[TOT-1]) begin
      out_data_r <= res;
    end
  end

  // A full last stage behind a stalled, occupied output must hold the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && v_r[TOT-1]) |-> !in_ready)
    else $error("input taken while the pipeline is blocked");

  a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |->
      ((out_data_r.radius == '0) && (out_data_r.momentum == '0)))
    else $error("special case gave a non-zero radius or momentum");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DIV_LAST] && !dovf_r[QW]) |-> (drem_r[QW] < RMW'(dd_r[QW])))
    else $error("divider remainder not below the divisor");

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[SQ_LAST] |-> (srem_r[RW] <= SRW'({sroot_r[RW], 1'b0})))
    else $error("square-root remainder exceeds twice the root");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_r[TOT-1]) |=> out_valid_r)
    else $error("finished result did not reach the output register");

endmodule

[tb/tpcm_checker.sv]
// Scoreboard for the three-point circle momentum block: watches both channels,
// predicts each result from the accepted hit triplet and compares field by field.
// Depends on tpcm_pkg.
module tpcm_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tpcm_pkg::in_data_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tpcm_pkg::out_data_t out_data,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpcm_pkg::*;

  out_data_t track_q[$];

  // Exact circle arithmetic in wide signed integers; 256 bits cover the
  // product of three squared chord lengths with room to spare.
  function automatic out_data_t circle_predict(in_data_t h);
    logic signed [255:0] az, ay, bz, by, cz, cy;
    logic signed [255:0] xp, na, nb, nc, num, den, side, cand, prod;
    logic signed [255:0] fld;
    logic [63:0] rad, fmag, mag;
    logic neg;
    out_data_t res;
    res = '0;
    res.status = ST_OK;
    az = 256'(h.z_middle) - 256'(h.z_first);
    ay = 256'(h.y_middle) - 256'(h.y_first);
    bz = 256'(h.z_last) - 256'(h.z_middle);
    by = 256'(h.y_last) - 256'(h.y_middle);
    cz = 256'(h.z_last) - 256'(h.z_first);
    cy = 256'(h.y_last) - 256'(h.y_first);
    xp = az * by - ay * bz;
    if (az == 0 || bz == 0) begin
      res.status = ST_VERT;
      return res;
    end
    if (xp == 0) begin
      res.status = ST_COLL;
      return res;
    end
    if (by == 0) begin
      res.status = ST_FLAT;
      return res;
    end
    na = az * az + ay * ay;
    nb = bz * bz + by * by;
    nc = cz * cz + cy * cy;
    num = na * nb * nc;
    den = 4 * xp * xp;
    rad = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = 256'(rad | (64'd1 << b));
      prod = cand * cand * den;
      if (prod <= num) rad = rad | (64'd1 << b);
    end
    // The middle hit is above the centre when the side term and the cross
    // product have opposite signs; level counts as below.
    side = az * nb + bz * na;
    neg = !((side > 0 && xp < 0) || (side < 0 && xp > 0));
    fld = 256'(h.field_x);
    if (fld < 0) begin
      neg = !neg;
      fmag = 64'(-fld);
    end else begin
      fmag = 64'(fld);
    end
    mag = (64'd300 * fmag * rad + 64'd2048) >> 12;
    res.radius = rad[31:0];
    if (mag == 0) res.momentum = '0;
    else if (!neg) res.momentum = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    else res.momentum = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return res;
  endfunction

  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      track_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) track_q = {track_q, circle_predict(in_data)};
      if (out_valid && out_ready) begin
        if (track_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result beat: %p", out_data);
        end else begin
          want = track_q.pop_front();
          if (want.radius !== out_data.radius || want.momentum !== out_data.momentum ||
              want.status !== out_data.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result mismatch: expected r=%0d p=%0d s=%0d, got r=%0d p=%0d s=%0d",
                       want.radius, want.momentum, want.status,
                       out_data.radius, out_data.momentum, out_data.status);
          end
        end
      end
      pending <= track_q.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the testbench: clock, reset, hit triplet stimulus, receiver stalls
// and the verdict. Depends on tpcm_pkg, tpcm_checker and the block's top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpcm_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_data_t in_data;
  out_data_t out_data;
  int mismatches, pending;
  int sent;
  bit long_hold_done;

  three_point_circle_momentum_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  tpcm_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .mismatches, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_data_t hits(int z1, int y1, int z2, int y2, int z3, int y3,
                                    int f);
    in_data_t h;
    h.z_first = z1; h.y_first = y1; h.z_middle = z2;
    h.y_middle = y2; h.z_last = z3; h.y_last = y3;
    h.field_x = 16'(f);
    return h;
  endfunction

  function automatic logic [31:0] coord_rand(int kind);
    unique case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(200000000)) - 100000000);
    endcase
  endfunction

  // Half genuine arcs with random scale; the rest forced onto each special case or a zero field.
  function automatic in_data_t random_hits();
    in_data_t h;
    int kind, shape;
    kind = $urandom_range(2);
    shape = $urandom_range(9);
    h.z_first = coord_rand(kind); h.y_first = coord_rand(kind);
    h.z_middle = coord_rand(kind); h.y_middle = coord_rand(kind);
    h.z_last = coord_rand(kind); h.y_last = coord_rand(kind);
    h.field_x = 16'($urandom());
    unique case (shape)
      0: h.z_middle = h.z_first;
      1: h.z_last = h.z_middle;
      2: h.y_last = h.y_middle;
      3: begin
        h.z_last = h.z_middle + (h.z_middle - h.z_first);
        h.y_last = h.y_middle + (h.y_middle - h.y_first);
      end
      4: h.field_x = 0;
      default: ;
    endcase
    return h;
  endfunction

  task automatic send_beat(in_data_t h);
    in_valid <= 1'b1;
    in_data <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Bursts of beats with random gaps; valid is only dropped when a gap follows.
  task automatic send_item(in_data_t h, ref int burst);
    int gap;
    send_beat(h);
    burst--;
    if (burst <= 0) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sent >= 300 && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1;
      end else if (sent < 150 || (sent > 600 && sent < 700)) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(3) != 0);
      end
    end
  end

  initial begin
    in_data_t dir[$];
    int burst, waited;
    in_valid = 0;
    in_data = '0;
    rst_n = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir = {dir, hits(0, 0, 1000, 500, 2000, 0, 4096)};
    dir = {dir, hits(0, 0, 1000, 500, 2000, 0, -4096)};
    dir = {dir, hits(0, 0, 1000, -500, 2000, 0, 4096)};
    dir = {dir, hits(0, 1, 1, 0, 0, -1, 4096)};          // middle level with centre
    dir = {dir, hits(5, 0, 5, 7, 9, 3, 100)};             // vertical first chord
    dir = {dir, hits(0, 0, 5, 7, 5, 3, 100)};             // vertical second chord
    dir = {dir, hits(0, 0, 10, 10, 20, 20, 100)};         // collinear
    dir = {dir, hits(0, 0, 10, 10, 20, 10, 100)};         // level second chord
    dir = {dir, hits(0, 0, 1000, 500, 2000, 0, 0)};       // zero field
    dir = {dir, hits(0, 0, 1000, 500, 2000, 0, 32767)};
    dir = {dir, hits(0, 0, 1000, 500, 2000, 0, -32768)};
    dir = {dir, hits(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, -32768)};
    dir = {dir, hits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                     32'h7FFF_FFFF, 32'h8000_0000, 32767)};
    dir = {dir, hits(32'h8000_0000, 0, 32'h8000_0001, 1, 32'h8000_0002, 0, 32767)};
    dir = {dir, hits(-1, -1, 0, 32'h7FFF_FFFF, 1, -1, -1)};
    dir = {dir, hits(0, 0, 1, 1, 2, 0, 1)};
    dir = {dir, hits(0, 0, 1, 1, 2, 0, 32'hFFFF_8000)};
    dir = {dir, hits(-100000000, 3, 0, 0, 100000000, 3, 4096)};

    burst = $urandom_range(1, 40);
    foreach (dir[i]) send_item(dir[i], burst);
    repeat (950) send_item(random_hits(), burst);
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
